// ===== hw/rtl/asgr_pkg.sv =====
package asgr_pkg;

    // Character codes
    localparam logic [7:0] CHAR_BEL  = 8'h07;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_ESC  = 8'h1B;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_LBRK = 8'h5B;
    localparam logic [7:0] CHAR_RBRK = 8'h5D;
    localparam logic [7:0] CHAR_SGR  = 8'h6D;  // 'm'
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;

    localparam logic [6:0] PARAM_MAX = 7'd127;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_ERASE = 2'd1,
        KIND_STYLE = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_RGB  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_RGB  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ITALIC    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDERLINE = 3'd4;

    typedef struct packed {
        logic [23:0] text_rgb;
        logic [23:0] back_rgb;
        logic [1:0]  weight;
        logic        italic;
        logic        underline;
    } style_t;

    localparam style_t RESET_STYLE = '{
        text_rgb:  24'hCCCCCC,
        back_rgb:  24'h000000,
        weight:    2'd0,
        italic:    1'b0,
        underline: 1'b0
    };

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_code;
        style_t     style;
        logic       last;
    } result_t;

    // Up to two results per accepted byte
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    // Output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [OQ_CNT_W-1:0] count;
    } oq_stat_t;

    function automatic logic [23:0] palette(input logic [3:0] idx);
        logic [23:0] c;
        case (idx)
            4'd0:  c = 24'h010101;
            4'd1:  c = 24'hDE382B;
            4'd2:  c = 24'h39B54A;
            4'd3:  c = 24'hFFC706;
            4'd4:  c = 24'h006FB8;
            4'd5:  c = 24'h762671;
            4'd6:  c = 24'h2CB5E9;
            4'd7:  c = 24'hCCCCCC;
            4'd8:  c = 24'h808080;
            4'd9:  c = 24'hFF0000;
            4'd10: c = 24'h00FF00;
            4'd11: c = 24'hFFFF00;
            4'd12: c = 24'h0000FF;
            4'd13: c = 24'hFF00FF;
            4'd14: c = 24'h00FFFF;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

    // CSI final letters other than 'm'
    function automatic logic is_final(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h48) || b == 8'h4A || b == 8'h4B ||
               b == 8'h53 || b == 8'h54 || b == 8'h66 || b == 8'h69 ||
               b == 8'h6E || b == 8'h75 || b == 8'h73;
    endfunction

    function automatic result_t make_result(input kind_t k, input logic [7:0] ch,
                                            input style_t s, input logic last);
        result_t r;
        r.kind      = k;
        r.char_code = ch;
        r.style     = s;
        r.last      = last;
        return r;
    endfunction

endpackage

// ===== hw/rtl/asgr_parse.sv =====
module asgr_parse
    import asgr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] byte_in,
    input  style_t     defaults,
    output push_t      push
);

    typedef enum logic [4:0] {
        MODE_NORMAL = 5'b00001,
        MODE_CR     = 5'b00010,
        MODE_ESC    = 5'b00100,
        MODE_OSC    = 5'b01000,
        MODE_CSI    = 5'b10000
    } mode_t;

    mode_t      mode_reg,  mode_next;
    logic [6:0] pv_reg,    pv_next;
    logic       digit_reg, digit_next;
    logic       bad_reg,   bad_next;
    style_t     pend_reg,  pend_next;
    style_t     cur_reg,   cur_next;
    logic       lf_reg,    lf_next;

    logic [10:0] pv_prod;
    logic [6:0]  pv_sat;
    style_t      tok_style;
    push_t       res;

    function automatic style_t apply_sgr(input style_t s, input logic [6:0] v,
                                         input style_t dflt);
        style_t o;
        logic [6:0] d;
        o = s;
        d = '0;
        if (v == 7'd0) begin
            o = dflt;
        end else if (v == 7'd1) begin
            o.weight = 2'd1;
        end else if (v == 7'd2) begin
            o.weight = 2'd2;
        end else if (v == 7'd3) begin
            o.italic = 1'b1;
        end else if (v == 7'd4) begin
            o.underline = 1'b1;
        end else if (v >= 7'd30 && v <= 7'd37) begin
            d = v - 7'd30;
            o.text_rgb = palette(d[3:0]);
        end else if (v >= 7'd90 && v <= 7'd97) begin
            d = v - 7'd82;
            o.text_rgb = palette(d[3:0]);
        end else if (v >= 7'd40 && v <= 7'd47) begin
            d = v - 7'd40;
            o.back_rgb = palette(d[3:0]);
        end else if (v >= 7'd100 && v <= 7'd107) begin
            d = v - 7'd92;
            o.back_rgb = palette(d[3:0]);
        end
        return o;
    endfunction

    // pv*10 + digit, saturating
    assign pv_prod = ({4'b0, pv_reg} << 3) + ({4'b0, pv_reg} << 1) + {7'b0, byte_in[3:0]};
    assign pv_sat  = (pv_prod > {4'b0, PARAM_MAX}) ? PARAM_MAX : pv_prod[6:0];

    assign tok_style = (digit_reg && !bad_reg) ? apply_sgr(pend_reg, pv_reg, defaults)
                                               : pend_reg;

    always_comb begin
        mode_next  = mode_reg;
        pv_next    = pv_reg;
        digit_next = digit_reg;
        bad_next   = bad_reg;
        pend_next  = pend_reg;
        cur_next   = cur_reg;
        lf_next    = lf_reg;
        res        = '0;

        unique case (mode_reg)
            MODE_CR: begin
                mode_next = MODE_NORMAL;
                if (byte_in == CHAR_LF) begin
                    res.n  = 2'd2;
                    res.r0 = make_result(KIND_TEXT, CHAR_CR, cur_reg, 1'b0);
                    res.r1 = make_result(KIND_TEXT, CHAR_LF, cur_reg, 1'b1);
                    lf_next = 1'b1;
                end else if (lf_reg) begin
                    // erase back to the last LF, then keep the byte
                    res.n  = 2'd2;
                    res.r0 = make_result(KIND_ERASE, 8'd0, cur_reg, 1'b0);
                    res.r1 = make_result(KIND_TEXT, byte_in, cur_reg, 1'b1);
                end else begin
                    res.n  = 2'd1;
                    res.r0 = make_result(KIND_ERASE, 8'd0, cur_reg, 1'b1);
                end
            end
            MODE_ESC: begin
                if (byte_in == CHAR_LBRK) begin
                    mode_next  = MODE_CSI;
                    pv_next    = '0;
                    digit_next = 1'b0;
                    bad_next   = 1'b0;
                    pend_next  = defaults;
                end else if (byte_in == CHAR_RBRK) begin
                    mode_next = MODE_OSC;
                end
            end
            MODE_OSC: begin
                if (byte_in == CHAR_BEL) begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_CSI: begin
                if (is_final(byte_in)) begin
                    mode_next = MODE_NORMAL;
                end else if (byte_in == CHAR_SGR) begin
                    pv_next    = '0;
                    digit_next = 1'b0;
                    bad_next   = 1'b0;
                    pend_next  = tok_style;
                    cur_next   = tok_style;
                    res.n      = 2'd1;
                    res.r0     = make_result(KIND_STYLE, 8'd0, tok_style, 1'b1);
                    mode_next  = MODE_NORMAL;
                end else if (byte_in == CHAR_SEMI) begin
                    pv_next    = '0;
                    digit_next = 1'b0;
                    bad_next   = 1'b0;
                    pend_next  = tok_style;
                end else if (byte_in >= CHAR_0 && byte_in <= CHAR_9) begin
                    pv_next    = pv_sat;
                    digit_next = 1'b1;
                end else begin
                    bad_next = 1'b1;
                end
            end
            default: begin
                mode_next = MODE_NORMAL;
                if (byte_in == CHAR_ESC) begin
                    lf_next   = 1'b0;
                    mode_next = MODE_ESC;
                end else if (byte_in == CHAR_CR) begin
                    mode_next = MODE_CR;
                end else begin
                    res.n  = 2'd1;
                    res.r0 = make_result(KIND_TEXT, byte_in, cur_reg, 1'b1);
                    if (byte_in == CHAR_LF) begin
                        lf_next = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            pv_reg    <= '0;
            digit_reg <= 1'b0;
            bad_reg   <= 1'b0;
            pend_reg  <= RESET_STYLE;
            cur_reg   <= RESET_STYLE;
            lf_reg    <= 1'b0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            pv_reg    <= pv_next;
            digit_reg <= digit_next;
            bad_reg   <= bad_next;
            pend_reg  <= pend_next;
            cur_reg   <= cur_next;
            lf_reg    <= lf_next;
        end
    end

    always_comb begin
        push   = res;
        push.n = accept ? res.n : 2'd0;
    end

endmodule

// ===== hw/rtl/asgr_outq.sv =====
module asgr_outq
    import asgr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  push_t    push,
    input  logic     pop,
    output logic     can_take,
    output logic     head_valid,
    output result_t  head,
    output oq_stat_t stat
);

    result_t             entry_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0] count_reg,  count_next;
    logic [OQ_PTR_W-1:0] wr_ptr_p1;

    assign wr_ptr_p1  = wr_ptr_reg + OQ_PTR_W'(1);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    // room for the worst case of two results
    assign can_take   = (count_reg <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign stat.count = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OQ_PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + OQ_PTR_W'(pop);
        count_next  = count_reg + OQ_CNT_W'(push.n) - OQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            entry_reg[wr_ptr_p1] <= push.r1;
        end
    end

endmodule

// ===== hw/rtl/ansi_escape_sgr_parser.sv =====
// Channel  | Handshake         | Payload
// ---------+-------------------+---------------------------------------------
// input    | s_valid/s_ready   | s_byte_in
// result   | m_valid/m_ready   | m_result_kind, m_char_code, m_text_rgb,
//          |                   | m_back_rgb, m_weight, m_italic, m_underline,
//          |                   | m_last
// config   | cfg_wr_en         | cfg_index, cfg_wr_data (no read-back)
//
// One byte is accepted per cycle while s_ready is high. Its results reach
// m_* behind any queued ones, one beat per cycle while m_ready is high; a CR
// pair or kept-byte CR-erase makes two beats; such bytes set the sustained rate.
// A 4-entry result queue sits between the parser and m_*: s_ready is high
// while at least two entries are free, so m_ready stalls back up into s_ready.
// aresetn is synchronous, active low; defaults and style return to reset
// values and the queue empties.
module ansi_escape_sgr_parser
    import asgr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_byte_in,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_result_kind,
    output logic [7:0]            m_char_code,
    output logic [23:0]           m_text_rgb,
    output logic [23:0]           m_back_rgb,
    output logic [1:0]            m_weight,
    output logic                  m_italic,
    output logic                  m_underline,
    output logic                  m_last
);

    style_t   dflt_reg;
    logic     in_accept;
    logic     out_pop;
    push_t    push;
    result_t  head;
    oq_stat_t q_stat;

    // Default style registers: written by index, low bits of the data word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_reg <= RESET_STYLE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TEXT_RGB:  dflt_reg.text_rgb  <= cfg_wr_data[23:0];
                CFG_BACK_RGB:  dflt_reg.back_rgb  <= cfg_wr_data[23:0];
                CFG_WEIGHT:    dflt_reg.weight    <= cfg_wr_data[1:0];
                CFG_ITALIC:    dflt_reg.italic    <= cfg_wr_data[0];
                CFG_UNDERLINE: dflt_reg.underline <= cfg_wr_data[0];
                default: ;     // unused indexes are ignored
            endcase
        end
    end

    assign in_accept = s_valid && s_ready;
    assign out_pop   = m_valid && m_ready;

    // Mode tracking, CSI token handling and style update; results leave
    // in the same cycle the byte is accepted and land in the queue.
    asgr_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (in_accept),
        .byte_in  (s_byte_in),
        .defaults (dflt_reg),
        .push     (push)
    );

    asgr_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (out_pop),
        .can_take   (s_ready),
        .head_valid (m_valid),
        .head       (head),
        .stat       (q_stat)
    );

    assign m_result_kind = head.kind;
    assign m_char_code   = head.char_code;
    assign m_text_rgb    = head.style.text_rgb;
    assign m_back_rgb    = head.style.back_rgb;
    assign m_weight      = head.style.weight;
    assign m_italic      = head.style.italic;
    assign m_underline   = head.style.underline;
    assign m_last        = head.last;

    // Queue never overfills
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overflow");

    // A byte's only result, or its second, closes the byte
    a_last_one: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n == 2'd1 |-> push.r0.last)
        else $error("single result without last");

    a_last_two: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n == 2'd2 |-> (!push.r0.last && push.r1.last))
        else $error("result pair with wrong last marks");

    // Pushes only happen on accepted beats
    a_push_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n != 2'd0 |-> in_accept)
        else $error("result pushed without an accepted beat");

    // Erase and style beats carry no character
    a_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind != KIND_TEXT) |-> m_char_code == 8'd0)
        else $error("non-text result with a character");

endmodule

// ===== bench/ansi_escape_sgr_parser_tb.sv =====
package sgr_check_pkg;
    import asgr_pkg::*;

    // SGR parameter numbers
    localparam int SGR_RESET     = 0;
    localparam int SGR_BOLD      = 1;
    localparam int SGR_LIGHT     = 2;
    localparam int SGR_ITALIC    = 3;
    localparam int SGR_UNDERLINE = 4;
    localparam int SGR_FG_BASE   = 30;
    localparam int SGR_BG_BASE   = 40;
    localparam int SGR_FG_BRIGHT = 90;
    localparam int SGR_BG_BRIGHT = 100;

    localparam logic [1:0] WEIGHT_BOLD  = 2'd1;
    localparam logic [1:0] WEIGHT_LIGHT = 2'd2;
    localparam int         PARAM_CEILING = 127;

    typedef enum logic [2:0] {
        MODE_TEXT,
        MODE_AFTER_CR,
        MODE_AFTER_ESC,
        MODE_OSC,
        MODE_CSI
    } mode_e;

    // CSI terminators that end the sequence without applying it
    function automatic bit is_csi_final(input logic [7:0] b);
        return (b >= "A" && b <= "H") || b == "J" || b == "K" || b == "S" ||
               b == "T" || b == "f" || b == "i" || b == "n" || b == "u" || b == "s";
    endfunction

    class sgr_tracker;
        style_t      defaults;
        style_t      building;     // style assembled by the SGR in progress
        style_t      active;
        mode_e       mode;
        int          token_value;
        bit          token_digit;
        bit          token_bad;
        bit          line_fed;
        logic [23:0] colors [16];
        result_t     expected_beats [$];
        int          mismatches;

        function new();
            colors = '{24'h010101, 24'hDE382B, 24'h39B54A, 24'hFFC706,
                       24'h006FB8, 24'h762671, 24'h2CB5E9, 24'hCCCCCC,
                       24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
                       24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF};
            defaults.text_rgb  = 24'hCCCCCC;
            defaults.back_rgb  = 24'h000000;
            defaults.weight    = 2'd0;
            defaults.italic    = 1'b0;
            defaults.underline = 1'b0;
            building    = defaults;
            active      = defaults;
            mode        = MODE_TEXT;
            token_value = 0;
            token_digit = 1'b0;
            token_bad   = 1'b0;
            line_fed    = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_default(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TEXT_RGB:  defaults.text_rgb  = data;
                CFG_BACK_RGB:  defaults.back_rgb  = data;
                CFG_WEIGHT:    defaults.weight    = data[1:0];
                CFG_ITALIC:    defaults.italic    = data[0];
                CFG_UNDERLINE: defaults.underline = data[0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return expected_beats.size();
        endfunction

        function result_t beat_of(kind_t k, logic [7:0] ch);
            result_t r;
            r.kind      = k;
            r.char_code = ch;
            r.style     = active;
            r.last      = 1'b0;
            return r;
        endfunction

        function void apply_sgr(int v);
            if (v == SGR_RESET) building = defaults;
            else if (v == SGR_BOLD) building.weight = WEIGHT_BOLD;
            else if (v == SGR_LIGHT) building.weight = WEIGHT_LIGHT;
            else if (v == SGR_ITALIC) building.italic = 1'b1;
            else if (v == SGR_UNDERLINE) building.underline = 1'b1;
            else if (v >= SGR_FG_BASE && v < SGR_FG_BASE + 8)
                building.text_rgb = colors[v - SGR_FG_BASE];
            else if (v >= SGR_FG_BRIGHT && v < SGR_FG_BRIGHT + 8)
                building.text_rgb = colors[v - SGR_FG_BRIGHT + 8];
            else if (v >= SGR_BG_BASE && v < SGR_BG_BASE + 8)
                building.back_rgb = colors[v - SGR_BG_BASE];
            else if (v >= SGR_BG_BRIGHT && v < SGR_BG_BRIGHT + 8)
                building.back_rgb = colors[v - SGR_BG_BRIGHT + 8];
        endfunction

        function void close_token();
            if (token_digit && !token_bad) apply_sgr(token_value);
            token_value = 0;
            token_digit = 1'b0;
            token_bad   = 1'b0;
        endfunction

        // Advance the parser by one accepted byte and queue the beats it causes
        function void note_byte(logic [7:0] b);
            result_t made [$];
            result_t tail;
            case (mode)
                MODE_AFTER_CR: begin
                    mode = MODE_TEXT;
                    if (b == CHAR_LF) begin
                        made.push_back(beat_of(KIND_TEXT, CHAR_CR));
                        made.push_back(beat_of(KIND_TEXT, CHAR_LF));
                        line_fed = 1'b1;
                    end else begin
                        made.push_back(beat_of(KIND_ERASE, 8'h00));
                        if (line_fed) made.push_back(beat_of(KIND_TEXT, b));
                    end
                end
                MODE_AFTER_ESC: begin
                    if (b == CHAR_LBRK) begin
                        mode        = MODE_CSI;
                        token_value = 0;
                        token_digit = 1'b0;
                        token_bad   = 1'b0;
                        building    = defaults;
                    end else if (b == CHAR_RBRK) begin
                        mode = MODE_OSC;
                    end
                end
                MODE_OSC: begin
                    if (b == CHAR_BEL) mode = MODE_TEXT;
                end
                MODE_CSI: begin
                    if (is_csi_final(b)) begin
                        mode = MODE_TEXT;
                    end else if (b == CHAR_SGR) begin
                        close_token();
                        active = building;
                        made.push_back(beat_of(KIND_STYLE, 8'h00));
                        mode = MODE_TEXT;
                    end else if (b == CHAR_SEMI) begin
                        close_token();
                    end else if (b >= CHAR_0 && b <= CHAR_9) begin
                        token_value = token_value * 10 + int'(b - CHAR_0);
                        if (token_value > PARAM_CEILING) token_value = PARAM_CEILING;
                        token_digit = 1'b1;
                    end else begin
                        token_bad = 1'b1;
                    end
                end
                default: begin
                    mode = MODE_TEXT;
                    if (b == CHAR_ESC) begin
                        line_fed = 1'b0;
                        mode     = MODE_AFTER_ESC;
                    end else if (b == CHAR_CR) begin
                        mode = MODE_AFTER_CR;
                    end else begin
                        made.push_back(beat_of(KIND_TEXT, b));
                        if (b == CHAR_LF) line_fed = 1'b1;
                    end
                end
            endcase
            if (made.size() > 0) begin
                tail = made.pop_back();
                tail.last = 1'b1;
                made.push_back(tail);
            end
            foreach (made[i]) expected_beats.push_back(made[i]);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_beat(result_t got);
            result_t want;
            if (expected_beats.size() == 0) begin
                report($sformatf("beat with nothing queued, kind %0d char %02h",
                                 got.kind, got.char_code));
                return;
            end
            want = expected_beats.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind: want %0d got %0d", want.kind, got.kind));
            if (got.char_code !== want.char_code)
                report($sformatf("char_code: want %02h got %02h", want.char_code, got.char_code));
            if (got.style.text_rgb !== want.style.text_rgb)
                report($sformatf("text_rgb: want %06h got %06h",
                                 want.style.text_rgb, got.style.text_rgb));
            if (got.style.back_rgb !== want.style.back_rgb)
                report($sformatf("back_rgb: want %06h got %06h",
                                 want.style.back_rgb, got.style.back_rgb));
            if (got.style.weight !== want.style.weight)
                report($sformatf("weight: want %0d got %0d", want.style.weight, got.style.weight));
            if (got.style.italic !== want.style.italic)
                report($sformatf("italic: want %0b got %0b", want.style.italic, got.style.italic));
            if (got.style.underline !== want.style.underline)
                report($sformatf("underline: want %0b got %0b",
                                 want.style.underline, got.style.underline));
            if (got.last !== want.last)
                report($sformatf("last: want %0b got %0b", want.last, got.last));
        endtask
    endclass

endpackage

module ansi_escape_sgr_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asgr_pkg::*;
    import sgr_check_pkg::*;

    localparam int PHASES          = 6;
    localparam int PRESSURE_PHASE  = 2;
    localparam int ITEMS_PER_PHASE = 192;
    localparam int HOLD_CYCLES     = 240;   // long receiver hold-off to back up the queue
    localparam int SETTLE_CYCLES   = 4;     // margin for the parser to settle
    localparam int DRAIN_TAIL      = 16;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_style_e;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_byte_in   = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [1:0]            m_result_kind;
    logic [7:0]            m_char_code;
    logic [23:0]           m_text_rgb;
    logic [23:0]           m_back_rgb;
    logic [1:0]            m_weight;
    logic                  m_italic;
    logic                  m_underline;
    logic                  m_last;

    sgr_tracker  tracker;
    logic [7:0]  burst [$];         // bytes of the segment about to be sent
    idle_style_e tx_style = IDLE_SOME;
    idle_style_e rx_style = IDLE_SOME;
    bit          hold_request = 1'b0;
    int          stalled_cycles = 0;

    ansi_escape_sgr_parser uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_in     (s_byte_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_char_code   (m_char_code),
        .m_text_rgb    (m_text_rgb),
        .m_back_rgb    (m_back_rgb),
        .m_weight      (m_weight),
        .m_italic      (m_italic),
        .m_underline   (m_underline),
        .m_last        (m_last)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Per-beat wait drawn by either side; IDLE_NONE gives back-to-back stretches
    function automatic int pick_wait(input idle_style_e style);
        case (style)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
            default:   return $urandom_range(0, 19);
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Segment builders: well-formed sequences with random content, plus noise
    // ---------------------------------------------------------------------
    function automatic void put_number(input int v);
        if (v >= 100) burst.push_back(CHAR_0 + 8'((v / 100) % 10));
        if (v >= 10)  burst.push_back(CHAR_0 + 8'((v / 10) % 10));
        burst.push_back(CHAR_0 + 8'(v % 10));
    endfunction

    // One SGR parameter token: empty, meaningful, meaningless, saturating or bad
    function automatic void put_token();
        logic [7:0] junk;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            // empty token, skipped by the parser
        end else if (pick <= 5) begin
            case ($urandom_range(0, 4))
                0: put_number($urandom_range(SGR_RESET, SGR_UNDERLINE));
                1: put_number(SGR_FG_BASE + $urandom_range(0, 7));
                2: put_number(SGR_FG_BRIGHT + $urandom_range(0, 7));
                3: put_number(SGR_BG_BASE + $urandom_range(0, 7));
                default: put_number(SGR_BG_BRIGHT + $urandom_range(0, 7));
            endcase
        end else if (pick <= 7) begin
            put_number($urandom_range(0, 255));
        end else if (pick == 8) begin
            // long digit string; the value pins at the ceiling once it passes 127
            repeat ($urandom_range(4, 6)) burst.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
        end else begin
            // token spoiled by a stray byte somewhere inside
            do junk = 8'($urandom_range(0, 255));
            while ((junk >= CHAR_0 && junk <= CHAR_9) || junk == CHAR_SEMI ||
                   junk == CHAR_SGR || is_csi_final(junk));
            if ($urandom_range(0, 1)) put_number($urandom_range(0, 107));
            burst.push_back(junk);
            if ($urandom_range(0, 1)) put_number($urandom_range(0, 107));
        end
    endfunction

    // Returns how many of the queued bytes do real work in the parser
    function automatic int build_segment();
        int         pick;
        int         start;
        int         ignored;
        int         n;
        logic [7:0] b;
        pick    = $urandom_range(0, 99);
        start   = burst.size();
        ignored = 0;
        if (pick < 30) begin
            // text run, mostly printable
            repeat ($urandom_range(1, 10)) begin
                if ($urandom_range(0, 7) == 0) b = 8'($urandom_range(0, 255));
                else b = 8'($urandom_range(8'h20, 8'h7E));
                burst.push_back(b);
            end
        end else if (pick < 50) begin
            // CR pair, or CR followed by anything (erase)
            burst.push_back(CHAR_CR);
            if ($urandom_range(0, 1)) burst.push_back(CHAR_LF);
            else burst.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 75) begin
            // SGR with 0..4 tokens
            burst.push_back(CHAR_ESC);
            burst.push_back(CHAR_LBRK);
            n = $urandom_range(0, 4);
            for (int t = 0; t < n; t++) begin
                if (t > 0) burst.push_back(CHAR_SEMI);
                put_token();
            end
            burst.push_back(CHAR_SGR);
        end else if (pick < 83) begin
            // CSI closed by some other final letter; style must not move
            burst.push_back(CHAR_ESC);
            burst.push_back(CHAR_LBRK);
            if ($urandom_range(0, 1)) put_number($urandom_range(0, 107));
            if ($urandom_range(0, 1)) begin
                burst.push_back(CHAR_SEMI);
                put_token();
            end
            do b = 8'($urandom_range(8'h41, 8'h75));   // 'A'..'u'
            while (!is_csi_final(b));
            burst.push_back(b);
        end else if (pick < 90) begin
            // OSC body swallowed up to BEL
            burst.push_back(CHAR_ESC);
            burst.push_back(CHAR_RBRK);
            n = $urandom_range(0, 6);
            repeat (n) begin
                do b = 8'($urandom_range(0, 255));
                while (b == CHAR_BEL);
                burst.push_back(b);
            end
            burst.push_back(CHAR_BEL);
            ignored = n;
        end else if (pick < 95) begin
            // unknown bytes after ESC are dropped, then a bare SGR
            burst.push_back(CHAR_ESC);
            n = $urandom_range(1, 2);
            repeat (n) begin
                do b = 8'($urandom_range(0, 255));
                while (b == CHAR_LBRK || b == CHAR_RBRK);
                burst.push_back(b);
            end
            burst.push_back(CHAR_LBRK);
            burst.push_back(CHAR_SGR);
            ignored = n;
        end else begin
            burst.push_back(8'($urandom_range(0, 255)));
        end
        return burst.size() - start - ignored;
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------
    // valid goes high after the drawn gap and holds until the beat is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_wait(tx_style);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_burst();
        foreach (burst[i]) send_byte(burst[i]);
        burst.delete();
    endtask

    // Wait until every queued beat has come out and the parser has settled.
    // It first steps past the last accepting edge so the monitor has booked that byte.
    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_wr_en high; caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        tracker.write_default(idx, data);
    endtask

    // Phase 0: all zero, phase 1: all ones (weight 3 too), later: random.
    // Narrow registers get random junk above their width.
    task automatic load_defaults(input int phase);
        logic [23:0]           fg;
        logic [23:0]           bg;
        logic [1:0]            wt;
        logic                  it;
        logic                  ul;
        logic [CFG_DATA_W-1:0] d;
        logic [CFG_IDX_W-1:0]  spare;
        if (phase == 0) begin
            fg = '0; bg = '0; wt = '0; it = 1'b0; ul = 1'b0;
        end else if (phase == 1) begin
            fg = '1; bg = '1; wt = '1; it = 1'b1; ul = 1'b1;
        end else begin
            fg = 24'($urandom);
            bg = 24'($urandom);
            wt = 2'($urandom_range(0, 3));
            it = 1'($urandom_range(0, 1));
            ul = 1'($urandom_range(0, 1));
        end
        write_reg(CFG_TEXT_RGB, fg);
        write_reg(CFG_BACK_RGB, bg);
        d = 24'($urandom); d[1:0] = wt;
        write_reg(CFG_WEIGHT, d);
        d = 24'($urandom); d[0] = it;
        write_reg(CFG_ITALIC, d);
        d = 24'($urandom); d[0] = ul;
        write_reg(CFG_UNDERLINE, d);
        if (phase >= 2) begin
            // an index past the register list must change nothing
            spare = CFG_UNDERLINE + 3'($urandom_range(1, 3));
            write_reg(spare, 24'($urandom));
        end
        cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Receiver: random ready gaps, plus one long hold-off on request
    // ---------------------------------------------------------------------
    initial begin
        int hold;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_request) begin
                hold = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                hold = pick_wait(rx_style);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: check result beats, feed accepted input beats to the tracker
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t beat;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                beat.kind            = kind_t'(m_result_kind);
                beat.char_code       = m_char_code;
                beat.style.text_rgb  = m_text_rgb;
                beat.style.back_rgb  = m_back_rgb;
                beat.style.weight    = m_weight;
                beat.style.italic    = m_italic;
                beat.style.underline = m_underline;
                beat.last            = m_last;
                tracker.check_beat(beat);
            end
            // results show up on m_* no earlier than the cycle after the byte is accepted, so order here is safe
            if (s_valid && s_ready) tracker.note_byte(s_byte_in);
            if ((m_valid && m_ready) || (s_valid && s_ready)) stalled_cycles <= 0;
            else stalled_cycles <= stalled_cycles + 1;
        end
    end

    // Watchdog: too long without any beat on either channel
    initial begin
        wait (stalled_cycles >= WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        int sent;
        tracker = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, under reset defaults: byte extremes, CR pair, CR erase with
        // the byte kept (line feed pending), flush by ESC, unknown byte after ESC,
        // saturated / empty / bad tokens, bright background, CR erase with the
        // byte dropped, OSC up to BEL, CSI ended by another final letter.
        burst = '{"A", 8'h00, 8'hFF,
                  CHAR_CR, CHAR_LF,
                  CHAR_CR, "z",
                  CHAR_ESC, "q", CHAR_LBRK, "1", "3", "0", CHAR_SEMI, CHAR_SEMI,
                  "4", "x", CHAR_SEMI, "1", "0", "7", CHAR_SGR,
                  CHAR_CR, "y",
                  CHAR_ESC, CHAR_RBRK, CHAR_BEL,
                  CHAR_ESC, CHAR_LBRK, "H"};
        send_burst();
        go_idle();

        for (int phase = 0; phase < PHASES; phase++) begin
            load_defaults(phase);
            if (phase == PRESSURE_PHASE) begin
                // sender keeps offering while the receiver sits on its hands
                tx_style     = IDLE_NONE;
                hold_request = 1'b1;
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 15) == 0) begin
                    rx_style = idle_style_e'($urandom_range(0, 2));
                    if (phase != PRESSURE_PHASE) tx_style = idle_style_e'($urandom_range(0, 2));
                end
                sent += build_segment();
                send_burst();
            end
            go_idle();
        end

        repeat (DRAIN_TAIL) @(posedge aclk);
        if (tracker.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/asgr_pkg.sv
hw/rtl/asgr_parse.sv
hw/rtl/asgr_outq.sv
hw/rtl/ansi_escape_sgr_parser.sv
bench/ansi_escape_sgr_parser_tb.sv
